>>> rtl/core/fpi_pkg.sv
// Shared types, codes and the command expansion table of the flash image programmer.
`default_nettype none
package fpi_pkg;

	// Flash geometry, fixed for the supported parts.
	localparam int PAGE_BYTES   = 256;
	localparam int SECTOR_BYTES = 4096;
	localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
	localparam int PAGE_CNT_W   = $clog2(PAGE_BYTES + 1);

	// Field and register widths.
	localparam int ADDR_W   = 24;
	localparam int LEN_W    = 25;
	localparam int END_W    = 26;
	localparam int TICK_W   = 16;
	localparam int CFG_W    = 25;
	localparam int STEP_W   = 4;
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

	// Flash command and status bytes.
	localparam logic [7:0] CMD_WREN  = 8'h06;
	localparam logic [7:0] CMD_RDSR  = 8'h05;
	localparam logic [7:0] CMD_PP    = 8'h02;
	localparam logic [7:0] CMD_SE    = 8'h20;
	localparam logic [7:0] CMD_RDID  = 8'h9F;
	localparam logic [7:0] BYTE_NONE = 8'h00;
	localparam logic [7:0] MFR_BLANK = 8'hFF;
	localparam int         SR_WIP_BIT = 0;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_DATA  = 2'd1,
		OP_REPLY = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_FLASH_OFFSET  = 2'd0,
		REG_IMAGE_LENGTH  = 2'd1,
		REG_ERASE_TIMEOUT = 2'd2,
		REG_PAGE_TIMEOUT  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ACT_SEND     = 3'd0,
		ACT_RAISE    = 3'd1,
		ACT_RST_LOW  = 3'd2,
		ACT_RST_HIGH = 3'd3,
		ACT_DONE     = 3'd4,
		ACT_NEED     = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_NO_FLASH      = 2'd1,
		ST_ERASE_TIMEOUT = 2'd2,
		ST_PAGE_TIMEOUT  = 2'd3
	} status_t;

	// Leading part of a command: what finishes the previous transfer.
	typedef enum logic [1:0] {
		PRE_NONE  = 2'd0,
		PRE_DATA  = 2'd1,
		PRE_ID    = 2'd2,
		PRE_RAISE = 2'd3
	} pre_t;

	// Trailing part of a command: what starts the next transfer.
	typedef enum logic [2:0] {
		TAIL_START      = 3'd0,
		TAIL_NEED       = 3'd1,
		TAIL_RAISE_POLL = 3'd2,
		TAIL_POLL_MORE  = 3'd3,
		TAIL_FINISH     = 3'd4,
		TAIL_SECTOR     = 3'd5,
		TAIL_PAGE       = 3'd6
	} tail_t;

	typedef struct packed {
		pre_t              pre;
		tail_t             tail;
		logic [7:0]        data_byte;
		logic [ADDR_W-1:0] addr;
		status_t           status;
	} cmd_t;

	typedef struct packed {
		act_t       action;
		logic [7:0] byte_out;
		logic       wants_reply;
		status_t    status_code;
		logic       last;
	} result_t;

	function automatic logic [STEP_W-1:0] pre_len(pre_t p);
		logic [STEP_W-1:0] n;
		case (p)
			PRE_DATA:  n = STEP_W'(1);
			PRE_ID:    n = STEP_W'(3);
			PRE_RAISE: n = STEP_W'(1);
			default:   n = STEP_W'(0);
		endcase
		return n;
	endfunction

	function automatic logic [STEP_W-1:0] tail_len(tail_t t);
		logic [STEP_W-1:0] n;
		case (t)
			TAIL_START:      n = STEP_W'(3);
			TAIL_NEED:       n = STEP_W'(1);
			TAIL_RAISE_POLL: n = STEP_W'(3);
			TAIL_POLL_MORE:  n = STEP_W'(1);
			TAIL_FINISH:     n = STEP_W'(2);
			TAIL_SECTOR:     n = STEP_W'(9);
			TAIL_PAGE:       n = STEP_W'(7);
			default:         n = STEP_W'(1);
		endcase
		return n;
	endfunction

	function automatic result_t mk_send(logic [7:0] b, logic wr);
		result_t r;
		r = '{action: ACT_SEND, byte_out: b, wants_reply: wr, status_code: ST_OK, last: 1'b0};
		return r;
	endfunction

	function automatic result_t mk_act(act_t a, status_t st);
		result_t r;
		r = '{action: a, byte_out: BYTE_NONE, wants_reply: 1'b0, status_code: st, last: 1'b0};
		return r;
	endfunction

	// Result item number k of command c.
	function automatic result_t fpi_expand(cmd_t c, logic [STEP_W-1:0] k);
		result_t           r;
		logic [STEP_W-1:0] lp;
		logic [STEP_W-1:0] lt;
		logic [STEP_W-1:0] t;
		lp = pre_len(c.pre);
		lt = tail_len(c.tail);
		t  = k - lp;
		r  = mk_send(BYTE_NONE, 1'b0);
		if (k < lp) begin
			case (c.pre)
				PRE_DATA:  r = mk_send(c.data_byte, 1'b0);
				PRE_ID:    r = (k == STEP_W'(2)) ? mk_act(ACT_RAISE, ST_OK)
				                                 : mk_send(BYTE_NONE, 1'b0);
				PRE_RAISE: r = mk_act(ACT_RAISE, ST_OK);
				default:   r = mk_send(BYTE_NONE, 1'b0);
			endcase
		end else begin
			case (c.tail)
				TAIL_START: begin
					case (t)
						STEP_W'(0): r = mk_act(ACT_RST_LOW, ST_OK);
						STEP_W'(1): r = mk_send(CMD_RDID, 1'b0);
						default:    r = mk_send(BYTE_NONE, 1'b1);
					endcase
				end
				TAIL_NEED: r = mk_act(ACT_NEED, ST_OK);
				TAIL_RAISE_POLL: begin
					case (t)
						STEP_W'(0): r = mk_act(ACT_RAISE, ST_OK);
						STEP_W'(1): r = mk_send(CMD_RDSR, 1'b0);
						default:    r = mk_send(BYTE_NONE, 1'b1);
					endcase
				end
				TAIL_POLL_MORE: r = mk_send(BYTE_NONE, 1'b1);
				TAIL_FINISH: begin
					r = (t == STEP_W'(0)) ? mk_act(ACT_RST_HIGH, ST_OK)
					                      : mk_act(ACT_DONE, c.status);
				end
				TAIL_SECTOR, TAIL_PAGE: begin
					case (t)
						STEP_W'(0): r = mk_send(CMD_WREN, 1'b0);
						STEP_W'(1): r = mk_act(ACT_RAISE, ST_OK);
						STEP_W'(2): r = mk_send((c.tail == TAIL_SECTOR) ? CMD_SE : CMD_PP, 1'b0);
						STEP_W'(3): r = mk_send(c.addr[23:16], 1'b0);
						STEP_W'(4): r = mk_send(c.addr[15:8], 1'b0);
						STEP_W'(5): r = mk_send(c.addr[7:0], 1'b0);
						STEP_W'(6): r = (c.tail == TAIL_SECTOR) ? mk_act(ACT_RAISE, ST_OK)
						                                        : mk_act(ACT_NEED, ST_OK);
						STEP_W'(7): r = mk_send(CMD_RDSR, 1'b0);
						default:    r = mk_send(BYTE_NONE, 1'b1);
					endcase
				end
				default: r = mk_act(ACT_NEED, ST_OK);
			endcase
			r.last = (t == lt - STEP_W'(1));
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/fpi_front.sv
// Front part: configuration registers, programming state and command classification.
`default_nettype none
module fpi_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [1:0]                  op,
	input  wire logic [7:0]                  data,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [fpi_pkg::CFG_W-1:0]   cfg_wdata,
	output logic                             cmd_push,
	output fpi_pkg::cmd_t                    cmd
);

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_ID         = 5'b00010,
		PH_ERASE_POLL = 5'b00100,
		PH_PAGE_DATA  = 5'b01000,
		PH_PAGE_POLL  = 5'b10000
	} phase_t;

	localparam int AW = fpi_pkg::ADDR_W;
	localparam int LW = fpi_pkg::LEN_W;
	localparam int EW = fpi_pkg::END_W;
	localparam int TW = fpi_pkg::TICK_W;
	localparam int PW = fpi_pkg::PAGE_CNT_W;
	localparam int SS = fpi_pkg::SECTOR_SHIFT;
	localparam logic [EW-1:0] SECTOR_EW = EW'(fpi_pkg::SECTOR_BYTES);
	localparam logic [LW-1:0] PAGE_LW   = LW'(fpi_pkg::PAGE_BYTES);

	logic [AW-1:0] offset_q;
	logic [LW-1:0] length_q;
	logic [TW-1:0] erase_to_q;
	logic [TW-1:0] page_to_q;
	logic [EW-1:0] erase_end;

	phase_t        phase_q, phase_d;
	logic [LW-1:0] sector_q, sector_d;
	logic [LW-1:0] pos_q, pos_d;
	logic [PW-1:0] pbl_q, pbl_d;
	logic [TW-1:0] busy_q, busy_d;

	logic [EW-1:0] span_end;
	logic [EW-1:0] first_sector;
	logic [EW-1:0] next_sector;
	logic [LW-1:0] pos_sel;
	logic [LW-1:0] remain;
	logic          pg_done;
	logic [PW-1:0] pg_len;
	logic [AW-1:0] pg_addr;
	logic [PW-1:0] pbl_dec;
	logic [TW-1:0] limit;
	logic          is_erase;

	// End of the erase range, rounded up to a sector; rebuilt from the registers every cycle.
	assign span_end     = EW'(offset_q) + EW'(length_q) + SECTOR_EW - EW'(1);
	assign erase_end    = {span_end[EW-1:SS], {SS{1'b0}}};
	assign first_sector = EW'({offset_q[AW-1:SS], {SS{1'b0}}});
	assign next_sector  = EW'(sector_q) + SECTOR_EW;

	// Next page setup, shared by the paths into programming.
	assign pos_sel = (phase_q == PH_PAGE_POLL) ? pos_q : '0;
	assign pg_done = (pos_sel >= length_q);
	assign remain  = length_q - pos_sel;
	assign pg_len  = (remain > PAGE_LW) ? PW'(fpi_pkg::PAGE_BYTES) : remain[PW-1:0];
	assign pg_addr = offset_q + pos_sel[AW-1:0];

	assign pbl_dec  = (pbl_q != '0) ? pbl_q - PW'(1) : '0;
	assign is_erase = (phase_q == PH_ERASE_POLL);
	assign limit    = is_erase ? erase_to_q : page_to_q;

	always_comb begin
		phase_d  = phase_q;
		sector_d = sector_q;
		pos_d    = pos_q;
		pbl_d    = pbl_q;
		busy_d   = busy_q;
		cmd_push = 1'b0;
		cmd      = '{pre: fpi_pkg::PRE_NONE, tail: fpi_pkg::TAIL_NEED, data_byte: data,
		             addr: pg_addr, status: fpi_pkg::ST_OK};
		if (in_valid) begin
			case (op)
				fpi_pkg::OP_START: begin
					if (phase_q == PH_IDLE) begin
						cmd_push = 1'b1;
						cmd.tail = fpi_pkg::TAIL_START;
						phase_d  = PH_ID;
					end
				end
				fpi_pkg::OP_DATA: begin
					if (phase_q == PH_PAGE_DATA) begin
						cmd_push = 1'b1;
						cmd.pre  = fpi_pkg::PRE_DATA;
						pos_d    = pos_q + LW'(1);
						pbl_d    = pbl_dec;
						if (pbl_dec == '0) begin
							cmd.tail = fpi_pkg::TAIL_RAISE_POLL;
							busy_d   = '0;
							phase_d  = PH_PAGE_POLL;
						end
					end
				end
				fpi_pkg::OP_REPLY: begin
					if (phase_q == PH_ID) begin
						cmd_push = 1'b1;
						cmd.pre  = fpi_pkg::PRE_ID;
						if (data == fpi_pkg::BYTE_NONE || data == fpi_pkg::MFR_BLANK) begin
							cmd.tail   = fpi_pkg::TAIL_FINISH;
							cmd.status = fpi_pkg::ST_NO_FLASH;
							phase_d    = PH_IDLE;
						end else begin
							pos_d = '0;
							if (first_sector < erase_end) begin
								sector_d = first_sector[LW-1:0];
								cmd.tail = fpi_pkg::TAIL_SECTOR;
								cmd.addr = first_sector[AW-1:0];
								busy_d   = '0;
								phase_d  = PH_ERASE_POLL;
							end else if (pg_done) begin
								cmd.tail = fpi_pkg::TAIL_FINISH;
								phase_d  = PH_IDLE;
							end else begin
								cmd.tail = fpi_pkg::TAIL_PAGE;
								pbl_d    = pg_len;
								phase_d  = PH_PAGE_DATA;
							end
						end
					end else if (phase_q == PH_ERASE_POLL || phase_q == PH_PAGE_POLL) begin
						cmd_push = 1'b1;
						if (data[fpi_pkg::SR_WIP_BIT]) begin
							if (busy_q > limit) begin
								cmd.pre    = fpi_pkg::PRE_RAISE;
								cmd.tail   = fpi_pkg::TAIL_FINISH;
								cmd.status = is_erase ? fpi_pkg::ST_ERASE_TIMEOUT
								                      : fpi_pkg::ST_PAGE_TIMEOUT;
								phase_d    = PH_IDLE;
							end else begin
								cmd.tail = fpi_pkg::TAIL_POLL_MORE;
							end
						end else begin
							cmd.pre = fpi_pkg::PRE_RAISE;
							if (is_erase && next_sector < erase_end) begin
								sector_d = next_sector[LW-1:0];
								cmd.tail = fpi_pkg::TAIL_SECTOR;
								cmd.addr = next_sector[AW-1:0];
								busy_d   = '0;
							end else begin
								if (is_erase) begin
									pos_d = '0;
								end
								if (pg_done) begin
									cmd.tail = fpi_pkg::TAIL_FINISH;
									phase_d  = PH_IDLE;
								end else begin
									cmd.tail = fpi_pkg::TAIL_PAGE;
									pbl_d    = pg_len;
									phase_d  = PH_PAGE_DATA;
								end
							end
						end
					end
				end
				default: begin
					if ((phase_q == PH_ERASE_POLL || phase_q == PH_PAGE_POLL) &&
					    busy_q != {TW{1'b1}}) begin
						busy_d = busy_q + TW'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			length_q    <= '0;
			erase_to_q  <= TW'(2000);
			page_to_q   <= TW'(500);
			phase_q     <= PH_IDLE;
			sector_q    <= '0;
			pos_q       <= '0;
			pbl_q       <= '0;
			busy_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fpi_pkg::REG_FLASH_OFFSET:  offset_q   <= cfg_wdata[AW-1:0];
					fpi_pkg::REG_IMAGE_LENGTH:  length_q   <= cfg_wdata[LW-1:0];
					fpi_pkg::REG_ERASE_TIMEOUT: erase_to_q <= cfg_wdata[TW-1:0];
					fpi_pkg::REG_PAGE_TIMEOUT:  page_to_q  <= cfg_wdata[TW-1:0];
					default: ;
				endcase
			end
			phase_q  <= phase_d;
			sector_q <= sector_d;
			pos_q    <= pos_d;
			pbl_q    <= pbl_d;
			busy_q   <= busy_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/fpi_cmdq.sv
// Short first-in first-out queue of classified commands between front and back.
`default_nettype none
module fpi_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire fpi_pkg::cmd_t cmd_in,
	output logic               full,
	input  wire logic          pop,
	output fpi_pkg::cmd_t      cmd_out,
	output logic               empty
);

	localparam int PTR_W = fpi_pkg::CMDQ_PTR_W;
	localparam int CNT_W = PTR_W + 1;

	fpi_pkg::cmd_t       slot_q [fpi_pkg::CMDQ_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_W'(fpi_pkg::CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign cmd_out = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/fpi_back.sv
// Back part: walks each queued command and delivers its result items through an output register.
`default_nettype none
module fpi_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_empty,
	input  wire fpi_pkg::cmd_t cmd,
	output logic               cmd_pop,
	input  wire logic          pop,
	output logic               out_valid,
	output fpi_pkg::result_t   result
);

	localparam int SW = fpi_pkg::STEP_W;

	logic [SW-1:0]     step_q;
	logic              valid_q;
	fpi_pkg::result_t  res_q;
	fpi_pkg::result_t  res_now;
	logic              advance;

	assign res_now   = fpi_pkg::fpi_expand(cmd, step_q);
	assign advance   = !cmd_empty && (!valid_q || pop);
	assign cmd_pop   = advance && res_now.last;
	assign out_valid = valid_q;
	assign result    = res_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				step_q  <= res_now.last ? '0 : step_q + SW'(1);
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/spi_flash_image_programmer.sv
// Top level of the SPI NOR flash image programmer: front, command queue and back.
//
// Channel   Direction  Handshake                     Payload
// input     in         push / full                   op, data
// result    out        empty / pop                   action, byte_out, wants_reply,
//                                                    status_code, last
// config    in         cfg_we (no wait, no readback) cfg_index, cfg_wdata
//
// An input item is classified in the cycle it is accepted; the front keeps the programming
// state, so the next item can be accepted in the very next cycle. Each item that causes
// results becomes one command in a four-deep queue, and the back walks that command at one
// result item per cycle while the output register is empty or being popped; a command gives
// one to twelve result items, set by the length of the command expansion in the back.
// full rises only while the command queue is full; a stalled result consumer therefore stops
// the input only after four commands have piled up. Reset clears the phase, counters, queue
// pointers and output valid, and loads the configuration registers with their reset values.
`default_nettype none
module spi_flash_image_programmer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Input items.
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [1:0]                op,
	input  wire logic [7:0]                data,
	// Result items.
	output logic                           empty,
	input  wire logic                      pop,
	output logic [2:0]                     action,
	output logic [7:0]                     byte_out,
	output logic                           wants_reply,
	output logic [1:0]                     status_code,
	output logic                           last,
	// Configuration writes.
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [fpi_pkg::CFG_W-1:0] cfg_wdata
);

	fpi_pkg::cmd_t     front_cmd;
	fpi_pkg::cmd_t     head_cmd;
	fpi_pkg::result_t  result;
	logic              front_push;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	logic              out_valid;
	logic              accept;

	// An item is taken whenever the queue has room, even if it ends up causing no result.
	assign accept = push && !q_full;
	assign full   = q_full;

	fpi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.op        (op),
		.data      (data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd_push  (front_push),
		.cmd       (front_cmd)
	);

	fpi_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_push),
		.cmd_in  (front_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.cmd_out (head_cmd),
		.empty   (q_empty)
	);

	fpi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (q_empty),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.pop       (pop),
		.out_valid (out_valid),
		.result    (result)
	);

	// The output register holds the oldest result item until it is popped.
	assign empty       = !out_valid;
	assign action      = result.action;
	assign byte_out    = result.byte_out;
	assign wants_reply = result.wants_reply;
	assign status_code = result.status_code;
	assign last        = result.last;

endmodule
`default_nettype wire
